/* hw/rtl/rc2cbc_pkg.sv */
// Shared types, constants and the RC2 permutation table for the CBC decrypt unit.
`timescale 1ns / 1ps
package rc2cbc_pkg;

  localparam int MaxKeyBytes = 128;

  localparam logic OP_LOAD_KEY = 1'b0;
  localparam logic OP_DECRYPT  = 1'b1;

  localparam logic [3:0] ADDR_KEY_LENGTH = 4'd0;
  localparam logic [3:0] ADDR_IV         = 4'd8;

  typedef struct packed {
    logic        operation;
    logic [6:0]  key_position;
    logic [7:0]  key_byte;
    logic [63:0] ciphertext_block;
    logic        restart_chain;
    logic        last_block;
  } cipher_beat_t;

  typedef struct packed {
    logic [63:0] plaintext_block;
    logic        final_block;
    logic        key_valid;
  } plain_beat_t;

  localparam logic [7:0] PI_TABLE [256] = '{
    8'hd9, 8'h78, 8'hf9, 8'hc4, 8'h19, 8'hdd, 8'hb5, 8'hed,
    8'h28, 8'he9, 8'hfd, 8'h79, 8'h4a, 8'ha0, 8'hd8, 8'h9d,
    8'hc6, 8'h7e, 8'h37, 8'h83, 8'h2b, 8'h76, 8'h53, 8'h8e,
    8'h62, 8'h4c, 8'h64, 8'h88, 8'h44, 8'h8b, 8'hfb, 8'ha2,
    8'h17, 8'h9a, 8'h59, 8'hf5, 8'h87, 8'hb3, 8'h4f, 8'h13,
    8'h61, 8'h45, 8'h6d, 8'h8d, 8'h09, 8'h81, 8'h7d, 8'h32,
    8'hbd, 8'h8f, 8'h40, 8'heb, 8'h86, 8'hb7, 8'h7b, 8'h0b,
    8'hf0, 8'h95, 8'h21, 8'h22, 8'h5c, 8'h6b, 8'h4e, 8'h82,
    8'h54, 8'hd6, 8'h65, 8'h93, 8'hce, 8'h60, 8'hb2, 8'h1c,
    8'h73, 8'h56, 8'hc0, 8'h14, 8'ha7, 8'h8c, 8'hf1, 8'hdc,
    8'h12, 8'h75, 8'hca, 8'h1f, 8'h3b, 8'hbe, 8'he4, 8'hd1,
    8'h42, 8'h3d, 8'hd4, 8'h30, 8'ha3, 8'h3c, 8'hb6, 8'h26,
    8'h6f, 8'hbf, 8'h0e, 8'hda, 8'h46, 8'h69, 8'h07, 8'h57,
    8'h27, 8'hf2, 8'h1d, 8'h9b, 8'hbc, 8'h94, 8'h43, 8'h03,
    8'hf8, 8'h11, 8'hc7, 8'hf6, 8'h90, 8'hef, 8'h3e, 8'he7,
    8'h06, 8'hc3, 8'hd5, 8'h2f, 8'hc8, 8'h66, 8'h1e, 8'hd7,
    8'h08, 8'he8, 8'hea, 8'hde, 8'h80, 8'h52, 8'hee, 8'hf7,
    8'h84, 8'haa, 8'h72, 8'hac, 8'h35, 8'h4d, 8'h6a, 8'h2a,
    8'h96, 8'h1a, 8'hd2, 8'h71, 8'h5a, 8'h15, 8'h49, 8'h74,
    8'h4b, 8'h9f, 8'hd0, 8'h5e, 8'h04, 8'h18, 8'ha4, 8'hec,
    8'hc2, 8'he0, 8'h41, 8'h6e, 8'h0f, 8'h51, 8'hcb, 8'hcc,
    8'h24, 8'h91, 8'haf, 8'h50, 8'ha1, 8'hf4, 8'h70, 8'h39,
    8'h99, 8'h7c, 8'h3a, 8'h85, 8'h23, 8'hb8, 8'hb4, 8'h7a,
    8'hfc, 8'h02, 8'h36, 8'h5b, 8'h25, 8'h55, 8'h97, 8'h31,
    8'h2d, 8'h5d, 8'hfa, 8'h98, 8'he3, 8'h8a, 8'h92, 8'hae,
    8'h05, 8'hdf, 8'h29, 8'h10, 8'h67, 8'h6c, 8'hba, 8'hc9,
    8'hd3, 8'h00, 8'he6, 8'hcf, 8'he1, 8'h9e, 8'ha8, 8'h2c,
    8'h63, 8'h16, 8'h01, 8'h3f, 8'h58, 8'he2, 8'h89, 8'ha9,
    8'h0d, 8'h38, 8'h34, 8'h1b, 8'hab, 8'h33, 8'hff, 8'hb0,
    8'hbb, 8'h48, 8'h0c, 8'h5f, 8'hb9, 8'hb1, 8'hcd, 8'h2e,
    8'hc5, 8'hf3, 8'hdb, 8'h47, 8'he5, 8'ha5, 8'h9c, 8'h77,
    8'h0a, 8'ha6, 8'h20, 8'h68, 8'hfe, 8'h7f, 8'hc1, 8'had
  };

endpackage

/* hw/rtl/rc2_cbc_decrypt_unit.sv */
// RC2 CBC decrypt unit: key load, key expansion and block decryption.
// Decrypt beat: 72 sub-rounds, each a read phase and a compute phase on the
//   single expanded-key read port, then the result is loaded into the output register; the
//   next beat is accepted only back in idle, and that load waits while the output is stalled.
// Key byte beat: stored in the raw key buffer; the final key byte adds the expansion (copy,
//   forward fill, fix, backward pass, pack) over the 128-byte work buffer and 64 key words.
// Reset (rst, synchronous): key length 8, IV zero, chain zero, key not ready;
//   the expanded key reads as zero until the first expansion completes.
`timescale 1ns / 1ps
module rc2_cbc_decrypt_unit #(
  parameter int MAX_KEY_BYTES = rc2cbc_pkg::MaxKeyBytes
) (
  input  logic                      clk,
  input  logic                      rst,
  // ciphertext / key-byte channel
  input  logic                      cipher_valid,
  output logic                      cipher_stall,
  input  rc2cbc_pkg::cipher_beat_t  cipher,
  // plaintext channel
  output logic                      plain_valid,
  input  logic                      plain_stall,
  output rc2cbc_pkg::plain_beat_t   plain,
  // APB config
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready
);
  import rc2cbc_pkg::*;

  localparam int RawAw = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [7:0] MaxLen = 8'(MAX_KEY_BYTES);
  // sub-round indexes of the two mashing steps
  localparam logic [6:0] Mash1Lo = 7'd20;
  localparam logic [6:0] Mash1Hi = 7'd23;
  localparam logic [6:0] Mash2Lo = 7'd48;
  localparam logic [6:0] Mash2Hi = 7'd51;
  localparam logic [6:0] LastSub = 7'd71;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_COPY = 8'b0000_0010,  // raw key -> work buffer
    ST_FWD  = 8'b0000_0100,  // forward fill
    ST_FIX  = 8'b0000_1000,  // single substitution at 128-T
    ST_BACK = 8'b0001_0000,  // backward pass
    ST_PACK = 8'b0010_0000,  // bytes -> 16-bit key words
    ST_DEC  = 8'b0100_0000,  // 72 sub-rounds
    ST_OUT  = 8'b1000_0000   // hand result to output register
  } state_t;

  state_t state;
  logic   ph;          // 0: memory read issued, 1: compute and write
  logic [7:0] i;       // expansion index
  logic [6:0] s;       // decrypt sub-round
  logic [5:0] j;       // mixing key index

  // config registers
  logic [7:0]  key_length;
  logic [63:0] initial_vector;

  // state
  logic [63:0] chain_value;
  logic        key_ready;
  logic [63:0] prev;
  logic        last_q;
  logic        kv_q;
  logic [3:0][15:0] r;

  // memories
  logic [7:0]  raw_mem [MAX_KEY_BYTES];
  logic [7:0]  kbuf    [128];
  logic [15:0] ek_mem  [64];
  logic [7:0]  raw_q, a_q, b_q;
  logic [15:0] ek_q;

  logic [6:0] addr_a, addr_b, addr_w;
  logic [5:0] ek_raddr;
  logic [7:0] t;
  logic [7:0] tail;    // 128 - T
  logic       accept;
  logic       load_ok;
  logic       cfg_wr;

  // ---------------- config port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr)
      ADDR_KEY_LENGTH: prdata = {56'd0, key_length};
      ADDR_IV:         prdata = initial_vector;
      default:         prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length     <= 8'd8;
      initial_vector <= 64'd0;
    end else if (cfg_wr) begin
      case (paddr)
        ADDR_KEY_LENGTH: key_length     <= pwdata[7:0];
        ADDR_IV:         initial_vector <= pwdata;
        default: ;
      endcase
    end
  end

  // effective key length T: zero acts as one, clipped to buffer size
  always_comb begin
    if (key_length == 8'd0) begin
      t = 8'd1;
    end else if (key_length > MaxLen) begin
      t = MaxLen;
    end else begin
      t = key_length;
    end
  end
  assign tail = 8'd128 - t;

  // ---------------- input handshake ----------------
  assign cipher_stall = (state != ST_IDLE);
  assign accept       = cipher_valid & ~cipher_stall;
  assign load_ok      = ({1'b0, cipher.key_position} < MaxLen);

  // ---------------- expansion addressing ----------------
  always_comb begin
    addr_a = i[6:0];
    addr_b = i[6:0];
    addr_w = i[6:0];
    case (state)
      ST_FWD: begin
        addr_a = 7'(i - 8'd1);
        addr_b = 7'(i - t);
      end
      ST_FIX: begin
        addr_a = tail[6:0];
        addr_w = tail[6:0];
      end
      ST_BACK: begin
        addr_a = i[6:0];
        addr_b = 7'(i - 8'd1 + t);
        addr_w = 7'(i - 8'd1);
      end
      ST_PACK: begin
        addr_a = {i[5:0], 1'b0};
        addr_b = {i[5:0], 1'b1};
      end
      default: ;
    endcase
  end

  // ---------------- decrypt datapath ----------------
  logic [1:0]  tgt;
  logic        mash;
  logic [15:0] x, a, b, c, rot, k, f, x_next;

  assign tgt  = ~s[1:0];
  assign mash = ((s >= Mash1Lo) && (s <= Mash1Hi)) || ((s >= Mash2Lo) && (s <= Mash2Hi));

  always_comb begin
    x = r[tgt];
    a = r[tgt - 2'd1];
    b = r[tgt - 2'd2];
    c = r[tgt - 2'd3];
    case (tgt)
      2'd3:    rot = {x[4:0], x[15:5]};
      2'd2:    rot = {x[2:0], x[15:3]};
      2'd1:    rot = {x[1:0], x[15:2]};
      default: rot = {x[0],   x[15:1]};
    endcase
  end

  assign ek_raddr = mash ? a[5:0] : j;
  assign k        = key_ready ? ek_q : 16'd0;  // unexpanded key reads as zero
  assign f        = (a & b) | (~a & c);
  assign x_next   = mash ? (x - k) : (rot - k - f);

  // ---------------- memories ----------------
  always_ff @(posedge clk) begin
    if (accept && cipher.operation == OP_LOAD_KEY && load_ok) begin
      raw_mem[cipher.key_position[RawAw-1:0]] <= cipher.key_byte;
    end
    raw_q <= raw_mem[i[RawAw-1:0]];
  end

  always_ff @(posedge clk) begin
    a_q <= kbuf[addr_a];
    b_q <= kbuf[addr_b];
    if (ph) begin
      case (state)
        ST_COPY: kbuf[addr_w] <= raw_q;
        ST_FWD:  kbuf[addr_w] <= PI_TABLE[8'(a_q + b_q)];
        ST_FIX:  kbuf[addr_w] <= PI_TABLE[a_q];
        ST_BACK: kbuf[addr_w] <= PI_TABLE[a_q ^ b_q];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ek_q <= ek_mem[ek_raddr];
    if (state == ST_PACK && ph) begin
      ek_mem[i[5:0]] <= {b_q, a_q};
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      ph          <= 1'b0;
      i           <= 8'd0;
      s           <= 7'd0;
      j           <= 6'd0;
      key_ready   <= 1'b0;
      chain_value <= 64'd0;
      plain_valid <= 1'b0;
    end else begin
      // ST_OUT handles its own valid when it reloads the output register
      if (plain_valid && !plain_stall && state != ST_OUT) begin
        plain_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          ph <= 1'b0;
          if (accept) begin
            if (cipher.operation == OP_DECRYPT) begin
              prev        <= cipher.restart_chain ? initial_vector : chain_value;
              chain_value <= cipher.ciphertext_block;
              r           <= cipher.ciphertext_block;
              last_q      <= cipher.last_block;
              kv_q        <= key_ready;
              s           <= 7'd0;
              j           <= 6'd63;
              state       <= ST_DEC;
            end else if (load_ok && ({1'b0, cipher.key_position} == t - 8'd1)) begin
              i     <= 8'd0;
              state <= ST_COPY;
            end
          end
        end
        ST_COPY: begin
          ph <= ~ph;
          if (ph) begin
            i <= i + 8'd1;
            if (i == t - 8'd1) begin
              state <= (t == 8'd128) ? ST_FIX : ST_FWD;
            end
          end
        end
        ST_FWD: begin
          ph <= ~ph;
          if (ph) begin
            i <= i + 8'd1;
            if (i == 8'd127) begin
              state <= ST_FIX;
            end
          end
        end
        ST_FIX: begin
          ph <= ~ph;
          if (ph) begin
            i     <= tail;
            state <= (tail == 8'd0) ? ST_PACK : ST_BACK;
          end
        end
        ST_BACK: begin
          ph <= ~ph;
          if (ph) begin
            i <= i - 8'd1;
            if (i == 8'd1) begin
              state <= ST_PACK;
            end
          end
        end
        ST_PACK: begin
          ph <= ~ph;
          if (ph) begin
            i <= i + 8'd1;
            if (i == 8'd63) begin
              key_ready <= 1'b1;
              state     <= ST_IDLE;
            end
          end
        end
        ST_DEC: begin
          ph <= ~ph;
          if (ph) begin
            r[tgt] <= x_next;
            if (!mash) begin
              j <= j - 6'd1;
            end
            s <= s + 7'd1;
            if (s == LastSub) begin
              state <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (!plain_valid || !plain_stall) begin
            plain.plaintext_block <= r ^ prev;
            plain.final_block     <= last_q;
            plain.key_valid       <= kv_q;
            plain_valid           <= 1'b1;
            state                 <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------- checks ----------------
  a_key_sticky: assert property (@(posedge clk) disable iff (rst)
    key_ready |=> key_ready) else $error("key_ready dropped");

  a_pack_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PACK && ph && i == 8'd63) |=> key_ready && state == ST_IDLE)
    else $error("expansion end did not set key_ready");

  a_dec_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DEC && ph && s == LastSub) |=> state == ST_OUT && j == 6'd63)
    else $error("decrypt sequence miscounted");

  a_chain: assert property (@(posedge clk) disable iff (rst)
    (accept && cipher.operation == OP_DECRYPT) |=> chain_value == $past(cipher.ciphertext_block))
    else $error("chain value not updated");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !(plain_valid && plain_stall)) |=> plain_valid)
    else $error("result not presented");

endmodule
